/* rtl/eenm_pkg.sv */
// eenm_pkg: shared types and constants for the embedded error norm maximum block
// no dependencies
`default_nettype none
package eenm_pkg;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned FracShift = 16;
  localparam logic [DataWidth-1:0] RatioMax = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_ACC,
    ST_ROOT,
    ST_NEXTVEC,
    ST_REL_LO,
    ST_REL_HI,
    ST_SCALE,
    ST_DIV,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef enum logic [0:0] {
    REG_ABS_TOL = 1'b0,
    REG_REL_TOL = 1'b1
  } reg_idx_t;
endpackage
`default_nettype wire

/* rtl/embedded_error_norm_max_top.sv */
// embedded_error_norm_max_top: per-node error norm, scale and running max ratio
// depends on eenm_pkg, eenm_sqrt, eenm_div
// sequence: an active node keeps the block busy from its accept: per vector the component
// squares, an accumulate and the root, then the scale, the divide and an update;
// a zero scale skips the divide, an inactive node only takes the update; a last node adds
// an emit state, its result is valid on the next cycle and is held until taken
// throughput: one node at a time, set by the serial root and divide units
// reset (rst, synchronous) clears tolerances, running maximum, invalid flag and handshakes
`default_nettype none
module embedded_error_norm_max_top
  import eenm_pkg::*;
#(
  parameter int unsigned COMPONENT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input item channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] err_x,
  input  wire logic [31:0] err_y,
  input  wire logic [31:0] err_z,
  input  wire logic [31:0] old_x,
  input  wire logic [31:0] old_y,
  input  wire logic [31:0] old_z,
  input  wire logic [31:0] new_x,
  input  wire logic [31:0] new_y,
  input  wire logic [31:0] new_z,
  input  wire logic        active,
  input  wire logic        last,
  // result item channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      error_ratio,
  output logic             invalid,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned CW = COMPONENT_WIDTH;

  // configuration registers
  logic [31:0] abs_tol;
  logic [31:0] rel_tol;
  logic        cfg_wr;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_tol <= '0;
      rel_tol <= '0;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (reg_idx_t'(reg_sel))
        REG_ABS_TOL: abs_tol <= pwdata;
        REG_REL_TOL: rel_tol <= pwdata;
        default:     abs_tol <= abs_tol;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(reg_sel))
      REG_ABS_TOL: prdata = abs_tol;
      REG_REL_TOL: prdata = rel_tol;
      default:     prdata = '0;
    endcase
  end

  // captured node
  logic [31:0] comp [9];
  logic        last_q;

  // sequencer state
  state_t      state, state_next;
  logic [1:0]  vec;       // vector being normed: error, old, new
  logic [1:0]  cmp;       // component being squared
  logic [65:0] acc;       // sum of squares
  logic [33:0] en, bign;  // error norm, larger state norm
  logic [63:0] rel;
  logic [33:0] scale;
  logic [31:0] running_max;
  logic        invalid_seen;

  // component magnitude through the shared squaring multiplier
  // (a magnitude never exceeds 32 bits, the fields being 32 bits wide)
  logic [3:0]    sel;
  logic [CW-1:0] raw;
  logic [CW-1:0] mag;
  logic [31:0]   mag32;
  logic [63:0]   sq;

  assign sel   = 4'(3 * vec + cmp);
  assign raw   = CW'(comp[sel]);
  assign mag   = raw[CW-1] ? CW'(~raw + 1'b1) : raw;
  assign mag32 = 32'(mag);
  assign sq    = 64'(mag32) * 64'(mag32);

  // shared multiplier output registered before the accumulate
  logic [63:0] sq_q;
  logic        sq_v;

  logic        rt_start, rt_go, rt_done;
  logic [33:0] root;
  logic        dv_start, dv_done;
  logic [49:0] quot;

  eenm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (rt_go),
    .radicand (acc),
    .done     (rt_done),
    .root     (root)
  );

  eenm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend ({en, 16'd0}),
    .divisor  (scale),
    .done     (dv_done),
    .quotient (quot)
  );

  logic accept_in;
  assign accept_in = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    rt_start   = 1'b0;
    dv_start   = 1'b0;
    case (state)
      ST_IDLE:    if (accept_in) state_next = active ? ST_SQ : ST_UPDATE;
      ST_SQ:      if (cmp == 2'd2) state_next = ST_ACC;
      ST_ACC: begin
        rt_start   = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT:    if (rt_done) state_next = ST_NEXTVEC;
      ST_NEXTVEC: state_next = (vec == 2'd2) ? ST_REL_LO : ST_SQ;
      ST_REL_LO:  state_next = ST_REL_HI;
      ST_REL_HI:  state_next = ST_SCALE;
      ST_SCALE: begin
        if (scale == '0) begin
          state_next = ST_UPDATE;
        end else begin
          dv_start   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV:     if (dv_done) state_next = ST_UPDATE;
      ST_UPDATE:  state_next = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // the last square lands in acc on the edge that leaves ST_ACC, so the root start is registered in rt_go
  always_ff @(posedge clk) begin
    if (rst) rt_go <= 1'b0;
    else     rt_go <= rt_start;
  end

  logic [63:0] prod_q;
  logic [31:0] ratio;
  assign ratio = (quot[49:32] != '0) ? RatioMax : quot[31:0];

  always_ff @(posedge clk) begin
    if (accept_in) begin
      comp[0] <= err_x; comp[1] <= err_y; comp[2] <= err_z;
      comp[3] <= old_x; comp[4] <= old_y; comp[5] <= old_z;
      comp[6] <= new_x; comp[7] <= new_y; comp[8] <= new_z;
      last_q  <= last;
      vec     <= '0;
      cmp     <= '0;
      acc     <= '0;
      sq_v    <= 1'b0;
      bign    <= '0;
    end
    case (state)
      ST_SQ: begin
        // one square issued per cycle, the previous one added
        sq_q <= sq;
        sq_v <= 1'b1;
        if (sq_v) acc <= acc + 66'(sq_q);
        if (cmp != 2'd2) cmp <= cmp + 2'd1;
      end
      ST_ACC: acc <= acc + 66'(sq_q);
      ST_ROOT: if (rt_done) begin
        if (vec == 2'd0) en <= root;
        else if (root > bign) bign <= root;
      end
      ST_NEXTVEC: begin
        if (vec != 2'd2) vec <= vec + 2'd1;
        cmp  <= '0;
        acc  <= '0;
        sq_v <= 1'b0;
      end
      ST_REL_LO: prod_q <= 64'(bign[31:0]) * 64'(rel_tol);
      ST_REL_HI: rel <= 64'(prod_q[63:32]) + 64'(bign[33:32]) * 64'(rel_tol);
      default: ;
    endcase
  end

  assign scale = 34'(abs_tol) + rel[33:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max  <= '0;
      invalid_seen <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == ST_SCALE && scale == '0) invalid_seen <= 1'b1;
      if (state == ST_DIV && dv_done && ratio > running_max) running_max <= ratio;
      if (state == ST_EMIT) begin
        out_valid    <= 1'b1;
        error_ratio  <= invalid_seen ? RatioMax : running_max;
        invalid      <= invalid_seen;
        running_max  <= '0;
        invalid_seen <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/eenm_sqrt.sv */
// eenm_sqrt: bit-serial integer square root of a 66-bit radicand, one root bit a cycle
// depends on eenm_pkg
`default_nettype none
module eenm_sqrt
  import eenm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [65:0] radicand,
  output logic             done,
  output logic [33:0]      root
);
  logic [65:0] rad;
  logic [35:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        take;

  assign rem_sh = {rem[33:0], rad[65:64]};
  assign trial  = {root, 2'b01};
  assign take   = rem_sh >= trial;

  // 33 bit pairs, one per busy cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[63:0], 2'b00};
      rem  <= take ? rem_sh - trial : rem_sh;
      root <= {root[32:0], take};
    end
  end
endmodule
`default_nettype wire

/* rtl/eenm_div.sv */
// eenm_div: restoring divider, 50-bit dividend by 34-bit divisor, one quotient bit a cycle
// depends on eenm_pkg
`default_nettype none
module eenm_div
  import eenm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [49:0] dividend,
  input  wire logic [33:0] divisor,
  output logic             done,
  output logic [49:0]      quotient
);
  logic [49:0] num;
  logic [34:0] rem;
  logic [33:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic [34:0] rem_sh;
  logic        take;

  assign rem_sh = {rem[33:0], num[49]};
  assign take   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd49;
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      den      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      num      <= {num[48:0], 1'b0};
      rem      <= take ? rem_sh - {1'b0, den} : rem_sh;
      quotient <= {quotient[48:0], take};
    end
  end
endmodule
`default_nettype wire

/* rtl/eenm_checker.sv */
// eenm_assertions: port-level assertions for embedded_error_norm_max_top
// depends on eenm_pkg; bound to the top level
`default_nettype none
module eenm_assertions
  import eenm_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] error_ratio,
  input wire logic        invalid
);
  // invalid result always reads as saturated
  a_inv_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> error_ratio == RatioMax) else $error("invalid not saturated");
  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(error_ratio) && $stable(invalid))
    else $error("result dropped");
  // no new item while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready with pending result");
  // an item accepted blocks the next edge
  a_seq: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("back to back accept");
endmodule

bind embedded_error_norm_max_top eenm_assertions u_eenm_assertions (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .error_ratio(error_ratio), .invalid(invalid)
);
`default_nettype wire
